/* sv/cluster_fit_chisquare_defines.svh */
// Assertion macros for the cluster fit block
`ifndef CLUSTER_FIT_CHISQUARE_DEFINES_SVH
`define CLUSTER_FIT_CHISQUARE_DEFINES_SVH
`ifndef SYNTHESIS
`define CFC_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
`define CFC_ASSERT_NEXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`else
`define CFC_ASSERT_IMP(label, clk, rst, a, c, msg)
`define CFC_ASSERT_NEXT(label, clk, rst, a, c, msg)
`endif
`endif

/* sv/cfc_pkg.sv */
`default_nettype none
package cfc_pkg;
   localparam int MAX_HITS_DEF  = 16;
   localparam int FRAC_BITS_DEF = 24;
   localparam int SUM_W         = 48;
   localparam int CNT_W         = 5;
   localparam int CSR_IDX_W     = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOPE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERCEPT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_IDX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIVOT_EN  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_MUL, ST_RESID, ST_DIV, ST_ACC, ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture a hit
      logic prep;      // sign rule, skip check
      logic mul;       // form products
      logic resid;     // pick side, start divide
      logic div_step;  // one quotient bit
      logic acc;       // add term, count hit
      logic clear;     // close cluster
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic skip;      // no work for this hit
      logic div_done;  // quotient complete or already decided
   } status_type;
endpackage
`default_nettype wire

/* sv/cluster_fit_chisquare.sv */
// Channel | Direction | Handshake               | Payload
// req     | in        | req_valid / req_stall   | drift_dist, wire_pos, drift_err, last_hit
// rsp     | out       | rsp_valid / rsp_stall   | chi2_sum, hits_used, saturated
// csr     | in        | csr_write               | csr_index, csr_data
// One hit at a time: a used hit goes through the bit-serial divider
// (82 quotient steps over a 66-bit magnitude); a skipped hit bypasses it.
// Zero divisor or overflow ends the divide early.
// Reset is synchronous and clears configuration and cluster state.
// The result of a last hit waits in the output registers while rsp_stall is high.
`default_nettype none
module cluster_fit_chisquare #(
   parameter int MAX_HITS  = cfc_pkg::MAX_HITS_DEF,
   parameter int FRAC_BITS = cfc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [cfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_data,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [31:0]            req_drift_dist,
   input  wire logic signed [31:0]            req_wire_pos,
   input  wire logic signed [31:0]            req_drift_err,
   input  wire logic                          req_last_hit,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [cfc_pkg::SUM_W-1:0]          rsp_chi2_sum,
   output logic [cfc_pkg::CNT_W-1:0]          rsp_hits_used,
   output logic                               rsp_saturated
);
   cfc_pkg::cmd_type    cmd;
   cfc_pkg::status_type sts;

   cfc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_last_hit(req_last_hit),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd)
   );

   cfc_dp #(.MAX_HITS(MAX_HITS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_drift_dist(req_drift_dist), .req_wire_pos(req_wire_pos),
      .req_drift_err(req_drift_err),
      .rsp_chi2_sum(rsp_chi2_sum), .rsp_hits_used(rsp_hits_used),
      .rsp_saturated(rsp_saturated)
   );
endmodule
`default_nettype wire

/* sv/cfc_ctrl.sv */
`default_nettype none
`include "cluster_fit_chisquare_defines.svh"
module cfc_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_last_hit,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire cfc_pkg::status_type sts,
   output cfc_pkg::cmd_type         cmd
);
   cfc_pkg::state_type state_ff, state_in;
   logic last_ff, last_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfc_pkg::ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         cfc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               last_in  = req_last_hit;
               state_in = cfc_pkg::ST_PREP;
            end
         end
         cfc_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = cfc_pkg::ST_MUL;
         end
         cfc_pkg::ST_MUL: begin
            if (sts.skip) begin
               state_in = last_ff ? cfc_pkg::ST_OUT : cfc_pkg::ST_IDLE;
            end else begin
               cmd.mul  = 1'b1;
               state_in = cfc_pkg::ST_RESID;
            end
         end
         cfc_pkg::ST_RESID: begin
            cmd.resid = 1'b1;
            state_in  = cfc_pkg::ST_DIV;
         end
         cfc_pkg::ST_DIV: begin
            if (sts.div_done) begin
               state_in = cfc_pkg::ST_ACC;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         cfc_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = last_ff ? cfc_pkg::ST_OUT : cfc_pkg::ST_IDLE;
         end
         cfc_pkg::ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.clear = 1'b1;
               state_in  = cfc_pkg::ST_IDLE;
            end
         end
         default: state_in = cfc_pkg::ST_IDLE;
      endcase
   end

   `CFC_ASSERT_IMP(a_rsp_only_out, clock, reset, rsp_valid, state_ff == cfc_pkg::ST_OUT, "rsp outside OUT")
   `CFC_ASSERT_NEXT(a_load_prep, clock, reset, cmd.load, state_ff == cfc_pkg::ST_PREP, "load not followed by prep")
   `CFC_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != cfc_pkg::ST_IDLE, req_stall, "accept while busy")
   `CFC_ASSERT_NEXT(a_out_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")
endmodule
`default_nettype wire

/* sv/cfc_dp.sv */
`default_nettype none
`include "cluster_fit_chisquare_defines.svh"
module cfc_dp #(
   parameter int MAX_HITS  = cfc_pkg::MAX_HITS_DEF,
   parameter int FRAC_BITS = cfc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire cfc_pkg::cmd_type                     cmd,
   output cfc_pkg::status_type                       sts,
   input  wire logic                                 csr_write,
   input  wire logic [cfc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [31:0]                          csr_data,
   input  wire logic signed [31:0]                   req_drift_dist,
   input  wire logic signed [31:0]                   req_wire_pos,
   input  wire logic signed [31:0]                   req_drift_err,
   output logic [cfc_pkg::SUM_W-1:0]                 rsp_chi2_sum,
   output logic [cfc_pkg::CNT_W-1:0]                 rsp_hits_used,
   output logic                                      rsp_saturated
);
   localparam int POS_W = $clog2(MAX_HITS + 1);
   localparam int SW    = cfc_pkg::SUM_W;
   localparam int DW    = 66;   // magnitude width of residual and divisor
   localparam int QW    = 33;   // 16.16 ratio plus one guard bit
   localparam int NBITS = DW + 16;
   localparam int SCNT  = $clog2(NBITS + 1);
   localparam logic signed [32:0] S32_MAX = 33'sd2147483647;
   localparam logic signed [32:0] S32_MIN = -33'sd2147483648;

   // configuration
   logic signed [31:0] slope_ff, icpt_ff, offs_ff;
   logic [3:0]         pidx_ff;
   logic               pen_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         slope_ff <= '0; icpt_ff <= '0; offs_ff <= '0; pidx_ff <= '0; pen_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            cfc_pkg::CSR_SLOPE:     slope_ff <= csr_data;
            cfc_pkg::CSR_INTERCEPT: icpt_ff  <= csr_data;
            cfc_pkg::CSR_OFFSET:    offs_ff  <= csr_data;
            cfc_pkg::CSR_PIVOT_IDX: pidx_ff  <= csr_data[3:0];
            cfc_pkg::CSR_PIVOT_EN:  pen_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v > S32_MAX) return 32'sh7fffffff;
      if (v < S32_MIN) return 32'sh80000000;
      return v[31:0];
   endfunction

   // hit capture
   logic signed [31:0] drift_ff, wire_ff, err_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         drift_ff <= req_drift_dist;
         wire_ff  <= req_wire_pos;
         err_ff   <= req_drift_err;
      end
   end

   // cluster state
   logic [POS_W-1:0]          pos_ff;
   logic [SW-1:0]             sum_ff;
   logic [cfc_pkg::CNT_W-1:0] used_ff;
   logic                      sat_ff;
   logic                      skip_ff, pivot_hit_ff;
   logic signed [31:0]        x_ff, xneg_ff;

   // sign rule
   logic [POS_W-1:0] pivot_num;
   logic signed [31:0] x_c;
   always_comb begin
      pivot_num = pen_ff ? POS_W'(pidx_ff) : '0;
      x_c = sat32(33'(drift_ff) + 33'(offs_ff));
      if (pos_ff > pivot_num) x_c = sat32(-33'(x_c));
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         x_ff         <= x_c;
         xneg_ff      <= sat32(-33'(x_c));
         skip_ff      <= (pos_ff >= POS_W'(MAX_HITS)) || (err_ff <= 0);
         pivot_hit_ff <= pen_ff && (pos_ff == POS_W'(pidx_ff));
      end
   end

   // products, one multiplier each, registered
   logic signed [63:0] p_y_ff, p_alt_ff, p_dy_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         p_y_ff   <= slope_ff * x_ff;
         p_alt_ff <= slope_ff * xneg_ff;
         p_dy_ff  <= slope_ff * err_ff;
      end
   end

   // residual and side selection
   logic signed [65:0] y_fit, y_alt, dy, resid, d_fit, d_alt;
   logic [DW-1:0] m_fit, m_alt;
   always_comb begin
      y_fit = 66'(p_y_ff >>> FRAC_BITS) + 66'(icpt_ff);
      y_alt = 66'(p_alt_ff >>> FRAC_BITS) + 66'(icpt_ff);
      dy    = 66'(p_dy_ff >>> FRAC_BITS);
      d_fit = 66'(wire_ff) - y_fit;
      d_alt = 66'(wire_ff) - y_alt;
      m_fit = d_fit[65] ? DW'(-d_fit) : DW'(d_fit);
      m_alt = d_alt[65] ? DW'(-d_alt) : DW'(d_alt);
      resid = (pivot_hit_ff && (m_fit > m_alt)) ? -d_alt : -d_fit;
   end

   // restoring divider: num * 2^16 / den, one bit a cycle
   logic [DW-1:0]    den_ff, rem_ff;
   logic [NBITS-1:0] num_ff;
   logic [QW-1:0]    q_ff;
   logic [SCNT-1:0]  cnt_ff;
   logic             zero_ff, over_ff;
   logic [DW:0]      rem_sh;
   always_comb rem_sh = {rem_ff, num_ff[NBITS-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.resid) begin
         num_ff  <= {(resid[65] ? DW'(-resid) : DW'(resid)), 16'd0};
         den_ff  <= dy[65] ? DW'(-dy) : DW'(dy);
         zero_ff <= (dy == 0);
         rem_ff  <= '0;
         q_ff    <= '0;
         over_ff <= 1'b0;
         cnt_ff  <= SCNT'(NBITS);
      end else if (cmd.div_step) begin
         num_ff <= num_ff << 1;
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_ff <= DW'(rem_sh - {1'b0, den_ff});
            q_ff   <= {q_ff[QW-2:0], 1'b1};
            if (q_ff[QW-1]) over_ff <= 1'b1;
         end else begin
            rem_ff <= rem_sh[DW-1:0];
            q_ff   <= {q_ff[QW-2:0], 1'b0};
            if (q_ff[QW-1]) over_ff <= 1'b1;
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // term and accumulate
   logic [2*QW-1:0] qsq;
   logic [SW:0]     sum_new;
   logic            bad;
   always_comb begin
      qsq     = q_ff * q_ff;
      sum_new = {1'b0, sum_ff} + (SW+1)'(qsq >> 16);
      bad     = zero_ff || over_ff || q_ff[QW-1] || sum_new[SW];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         pos_ff <= '0; sum_ff <= '0; used_ff <= '0; sat_ff <= 1'b0;
      end else begin
         if (cmd.prep && pos_ff < POS_W'(MAX_HITS)) pos_ff <= pos_ff + 1'b1;
         if (cmd.acc) begin
            used_ff <= used_ff + 1'b1;
            if (!sat_ff) begin
               if (bad) begin
                  sum_ff <= '1;
                  sat_ff <= 1'b1;
               end else begin
                  sum_ff <= sum_new[SW-1:0];
               end
            end
         end
      end
   end

   assign sts.skip     = skip_ff;
   assign sts.div_done = (cnt_ff == '0) || zero_ff || over_ff;
   assign rsp_chi2_sum  = sum_ff;
   assign rsp_hits_used = used_ff;
   assign rsp_saturated = sat_ff;

   `CFC_ASSERT_IMP(a_sat_sum, clock, reset, sat_ff, sum_ff == '1, "saturated sum not all ones")
   `CFC_ASSERT_NEXT(a_clear, clock, reset, cmd.clear, sum_ff == '0 && used_ff == '0, "clear failed")
   `CFC_ASSERT_IMP(a_pos_bound, clock, reset, 1'b1, pos_ff <= POS_W'(MAX_HITS), "position overrun")
endmodule
`default_nettype wire

/* test/cluster_fit_chisquare_chk.sv */
`timescale 1ns / 100ps
`default_nettype none
module cluster_fit_chisquare_chk (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic [cfc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                   csr_data,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic signed [31:0]            req_drift_dist,
   input  wire logic signed [31:0]            req_wire_pos,
   input  wire logic signed [31:0]            req_drift_err,
   input  wire logic                          req_last_hit,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [cfc_pkg::SUM_W-1:0]     rsp_chi2_sum,
   input  wire logic [cfc_pkg::CNT_W-1:0]     rsp_hits_used,
   input  wire logic                          rsp_saturated,
   output int                                 fail_count,
   output int                                 pending_count,
   output int                                 cluster_count
);
   localparam int HIT_LIMIT = cfc_pkg::MAX_HITS_DEF;
   localparam int FRAC = cfc_pkg::FRAC_BITS_DEF;
   localparam logic [47:0] SUM_ALL_ONES = '1;

   typedef struct packed {
      logic [47:0] chi2;
      logic [4:0]  used;
      logic        sat;
   } cluster_result_type;

   // line fit setup
   logic signed [31:0] slope_q, icept_q, offset_q;
   logic [3:0]         pivot_pos;
   logic               pivot_on;
   // running cluster state
   int unsigned        hit_pos;
   logic [47:0]        chi2_run;
   logic [4:0]         used_run;
   logic               sat_run;

   cluster_result_type fit_results_q[$];

   function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Q8.24 product, floor rounding
   function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p >>> FRAC;
   endfunction

   function automatic logic [63:0] absval(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   task automatic add_residual(logic signed [63:0] resid, logic signed [63:0] dy);
      logic [63:0]  num, den, ip, rem, q;
      logic [127:0] sq;
      logic [63:0]  term;
      if (sat_run) return;
      if (dy == 0) begin
         chi2_run = SUM_ALL_ONES; sat_run = 1'b1; return;
      end
      num = absval(resid);
      den = absval(dy);
      ip = num / den;
      if (ip >= 64'd65536) begin
         chi2_run = SUM_ALL_ONES; sat_run = 1'b1; return;
      end
      rem = num % den;
      q = ip;
      for (int i = 0; i < 16; i++) begin
         rem = rem << 1;
         q = q << 1;
         if (rem >= den) begin
            rem = rem - den; q[0] = 1'b1;
         end
      end
      sq = q * q;
      term = sq[79:16];
      if (term > {16'd0, SUM_ALL_ONES - chi2_run}) begin
         chi2_run = SUM_ALL_ONES; sat_run = 1'b1; return;
      end
      chi2_run = chi2_run + term[47:0];
   endtask

   task automatic predict_hit(logic signed [31:0] drift, logic signed [31:0] wire_y,
                              logic signed [31:0] err, logic last);
      logic [3:0]         pivot_num;
      logic signed [63:0] x, y_fit, y_alt, dy;
      cluster_result_type r;
      if (hit_pos < HIT_LIMIT) begin
         pivot_num = pivot_on ? pivot_pos : 4'd0;
         x = clamp32(64'(drift) + 64'(offset_q));
         if (hit_pos > pivot_num) x = clamp32(-x);
         if (err > 0) begin
            y_fit = qmul(64'(slope_q), x) + 64'(icept_q);
            // two-sided test at the pivot; ties keep the original side
            if (pivot_on && hit_pos == pivot_pos) begin
               y_alt = qmul(64'(slope_q), clamp32(-x)) + 64'(icept_q);
               if (absval(64'(wire_y) - y_fit) > absval(64'(wire_y) - y_alt)) y_fit = y_alt;
            end
            dy = qmul(64'(slope_q), 64'(err));
            add_residual(y_fit - 64'(wire_y), dy);
            used_run = used_run + 5'd1;
         end
         hit_pos++;
      end
      if (last) begin
         r.chi2 = chi2_run; r.used = used_run; r.sat = sat_run;
         fit_results_q = {fit_results_q, r};
         hit_pos = 0; chi2_run = '0; used_run = '0; sat_run = 1'b0;
      end
   endtask

   // config, prediction and comparison at each rising edge
   always @(posedge clock) begin
      cluster_result_type e;
      if (reset) begin
         slope_q <= '0; icept_q <= '0; offset_q <= '0; pivot_pos <= '0; pivot_on <= 1'b0;
         hit_pos = 0; chi2_run = '0; used_run = '0; sat_run = 1'b0;
         fit_results_q.delete();
         fail_count <= 0;
         cluster_count <= 0;
         pending_count <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               cfc_pkg::CSR_SLOPE:     slope_q <= csr_data;
               cfc_pkg::CSR_INTERCEPT: icept_q <= csr_data;
               cfc_pkg::CSR_OFFSET:    offset_q <= csr_data;
               cfc_pkg::CSR_PIVOT_IDX: pivot_pos <= csr_data[3:0];
               cfc_pkg::CSR_PIVOT_EN:  pivot_on <= csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            predict_hit(req_drift_dist, req_wire_pos, req_drift_err, req_last_hit);
         if (rsp_valid && !rsp_stall) begin
            cluster_count <= cluster_count + 1;
            if (fit_results_q.size() == 0) begin
               $display("%0t: unexpected result beat chi2=%h used=%0d sat=%b",
                        $time, rsp_chi2_sum, rsp_hits_used, rsp_saturated);
               fail_count <= fail_count + 1;
            end else begin
               e = fit_results_q.pop_front();
               if (e.chi2 !== rsp_chi2_sum || e.used !== rsp_hits_used
                   || e.sat !== rsp_saturated) begin
                  $display("%0t: mismatch exp chi2=%h used=%0d sat=%b act chi2=%h used=%0d sat=%b",
                           $time, e.chi2, e.used, e.sat,
                           rsp_chi2_sum, rsp_hits_used, rsp_saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= fit_results_q.size();
      end
   end
endmodule
`default_nettype wire

/* test/cluster_fit_chisquare_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module cluster_fit_chisquare_tb;
   logic                          clock, reset;
   logic                          csr_write;
   logic [cfc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                   csr_data;
   logic                          req_valid, req_stall;
   logic signed [31:0]            req_drift_dist, req_wire_pos, req_drift_err;
   logic                          req_last_hit;
   logic                          rsp_valid, rsp_stall;
   logic [cfc_pkg::SUM_W-1:0]     rsp_chi2_sum;
   logic [cfc_pkg::CNT_W-1:0]     rsp_hits_used;
   logic                          rsp_saturated;
   int                            fail_count, pending_count, cluster_count;
   int                            hit_count;
   bit                            calm_mode;

   cluster_fit_chisquare i_dut (.*);
   cluster_fit_chisquare_chk i_chk (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("Regression FAIL");
      $finish;
   end

   // result side stall, quiet during calm stretch
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= !calm_mode && ($urandom_range(99) < 15);
      end
   end

   function automatic logic [31:0] rand_q();
      case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'(int'($urandom_range(8'hFF)) - 128) << 16;
         3: return 32'($urandom_range(32'h0200_0000));
         default: return $urandom;
      endcase
   endfunction

   task automatic write_reg(logic [cfc_pkg::CSR_IDX_W-1:0] idx, logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_fit(logic [31:0] s, logic [31:0] b, logic [31:0] off,
                          logic [3:0] pidx, logic pen);
      // quiesce: wait for outstanding results plus skipped-hit work
      while (pending_count != 0) @(negedge clock);
      repeat (120) @(negedge clock);
      write_reg(cfc_pkg::CSR_SLOPE, s);
      write_reg(cfc_pkg::CSR_INTERCEPT, b);
      write_reg(cfc_pkg::CSR_OFFSET, off);
      write_reg(cfc_pkg::CSR_PIVOT_IDX, {28'd0, pidx});
      write_reg(cfc_pkg::CSR_PIVOT_EN, {31'd0, pen});
   endtask

   task automatic send_hit(logic [31:0] d, logic [31:0] w, logic [31:0] e, logic last);
      @(negedge clock);
      if (!calm_mode) begin
         while ($urandom_range(99) < 15) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_drift_dist <= d; req_wire_pos <= w; req_drift_err <= e; req_last_hit <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      req_valid <= 1'b0;
      hit_count++;
   endtask

   // cluster of n hits in bounded ranges, or from rand_q when noisy
   task automatic send_cluster(int n, bit noisy);
      logic [31:0] e;
      for (int i = 0; i < n; i++) begin
         e = noisy ? rand_q() : 32'($urandom_range(32'h0100_0000, 32'h0001_0000));
         if (!noisy && $urandom_range(9) == 0) e = 0;
         send_hit(noisy ? rand_q() : 32'($urandom_range(32'h0100_0000)),
                  noisy ? rand_q() : 32'(int'($urandom_range(32'h0040_0000)) - 32'h0020_0000),
                  e, i == n - 1);
      end
   endtask

   initial begin
      calm_mode = 1'b0;
      hit_count = 0;
      reset = 1'b1;
      csr_write = 1'b0; csr_index = '0; csr_data = '0;
      req_valid = 1'b0; req_drift_dist = 0; req_wire_pos = 0; req_drift_err = 0;
      req_last_hit = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: zero slope saturates, extremes, pivot, long cluster, skips
      send_hit(32'h0100_0000, 32'h0, 32'h0100_0000, 1'b1);
      set_fit(32'h0100_0000, 32'h0, 32'h0, 4'd2, 1'b1);
      send_hit(32'h0080_0000, 32'h0080_0000, 32'h0100_0000, 1'b0);
      send_hit(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      send_hit(32'h0040_0000, 32'hFFC0_0000, 32'h0100_0000, 1'b0);
      send_hit(32'h0040_0000, 32'h0040_0000, 32'h0000_0000, 1'b0);
      send_hit(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
      set_fit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 4'd15, 1'b1);
      for (int i = 0; i < 18; i++)
         send_hit(32'h0010_0000, 32'h0, 32'h0000_0001, i == 17);
      set_fit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 4'd0, 1'b0);
      send_hit(32'h8000_0000, 32'h0, 32'h0100_0000, 1'b0);
      send_hit(32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1);

      // random: mostly well-formed clusters, some noise, several fit settings
      while (hit_count < 900) begin
         if ($urandom_range(3) == 0)
            set_fit($urandom_range(7) == 0 ? rand_q() : 32'($urandom_range(32'h0300_0000)),
                    rand_q() >>> 6, $urandom_range(3) == 0 ? rand_q() : 32'h0,
                    4'($urandom), 1'($urandom));
         calm_mode = (hit_count > 400 && hit_count < 520);
         send_cluster($urandom_range(20) == 0 ? 19 : $urandom_range(1, 8),
                      $urandom_range(4) == 0);
      end
      calm_mode = 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("Sent %0d hits in clusters; %0d cluster results checked across fit settings.",
               hit_count, cluster_count);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
